@@ rtl/css_pkg.sv @@
// css_pkg: shared types and constants of the cosine similarity stream block
// used by css_ctrl, css_dp and cosine_similarity_stream; no dependencies
package css_pkg;

    // element and accumulator widths
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int SQ_W   = 43;
    localparam int DOT_W  = 44;
    localparam int SIM_W  = 16;

    // finishing arithmetic widths
    localparam int WIDE_W = 2 * SQ_W;
    localparam int ROOT_W = SQ_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int DEN_W  = DOT_W;
    localparam int QUO_W  = 17;
    localparam int CNT_W  = 6;

    // step counts, minus one, of the shared counter
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(SQ_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);

    // eps of 1e-6 in Q2.30 units, rounded to nearest
    localparam logic [DEN_W-1:0] EPS_FIX = DEN_W'(1074);

    // magnitude limits of the Q1.15 result
    localparam logic [QUO_W-1:0] SIM_POS_MAX = QUO_W'(32767);
    localparam logic [QUO_W-1:0] SIM_NEG_MAX = QUO_W'(32768);

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_MUL_LD,
        S_MUL,
        S_SQRT_LD,
        S_SQRT,
        S_DIV_LD,
        S_DIV,
        S_RES
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_mul;
        logic step_mul;
        logic load_sqrt;
        logic step_sqrt;
        logic load_div;
        logic step_div;
        logic load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic zero_norm;
        logic cnt_zero;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/cosine_similarity_stream.sv @@
// cosine_similarity_stream: top level, joins controller and datapath
// depends on css_pkg, css_ctrl and css_dp
//
// Input channel: i_in_valid / o_in_stall carry one element pair (i_elem_a,
// i_elem_b, signed Q1.15) per transaction; i_last marks the final pair of a
// vector. A transaction happens at a rising edge with valid high, stall low.
// Output channel: o_out_valid / i_out_stall carry one result per vector:
// o_similarity (signed Q1.15, saturated) and o_zero_norm.
// Throughput: one pair per cycle inside a vector. After the last pair the
// input stalls while the finishing sequence runs: the accumulate state, a load,
// the shift-add multiply steps, a load, the square root steps, a load,
// the divide steps and the result state.
// The multiply, root and divide share one step counter and run in sequence.
// A vector whose either sum of squares is zero skips to the result cycle.
// If the receiver stalls, the result waits in the output register; the next
// vector is accepted meanwhile, and its result waits for the register.
// Reset (i_rst_n low, synchronous) clears accumulators and handshake state.
module cosine_similarity_stream (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [css_pkg::ELEM_W-1:0] i_elem_a,
    input  logic signed [css_pkg::ELEM_W-1:0] i_elem_b,
    input  logic                              i_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [css_pkg::SIM_W-1:0]  o_similarity,
    output logic                              o_zero_norm
);

    css_pkg::t_cmd cmd;
    css_pkg::t_sts sts;
    logic          busy;
    logic          in_accept;

    // input transaction
    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !busy;

    css_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_last      (i_last),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    css_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_accept  (in_accept),
        .i_elem_a     (i_elem_a),
        .i_elem_b     (i_elem_b),
        .i_last       (i_last),
        .i_out_stall  (i_out_stall),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_similarity (o_similarity),
        .o_zero_norm  (o_zero_norm)
    );

endmodule

@@ rtl/css_ctrl.sv @@
// css_ctrl: sequencer for accumulate, multiply, square root and divide phases
// depends on css_pkg for the state enum and the command and status structs
module css_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_accept,
    input  logic           i_last,
    input  css_pkg::t_sts  i_sts,
    output css_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    css_pkg::t_state r_state;
    css_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= css_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            css_pkg::S_IDLE: begin
                if (i_in_accept && i_last) n_state = css_pkg::S_ACC;
            end
            css_pkg::S_ACC: begin
                n_state = css_pkg::S_MUL_LD;
            end
            css_pkg::S_MUL_LD: begin
                n_state = i_sts.zero_norm ? css_pkg::S_RES : css_pkg::S_MUL;
            end
            css_pkg::S_MUL: begin
                if (i_sts.cnt_zero) n_state = css_pkg::S_SQRT_LD;
            end
            css_pkg::S_SQRT_LD: begin
                n_state = css_pkg::S_SQRT;
            end
            css_pkg::S_SQRT: begin
                if (i_sts.cnt_zero) n_state = css_pkg::S_DIV_LD;
            end
            css_pkg::S_DIV_LD: begin
                n_state = css_pkg::S_DIV;
            end
            css_pkg::S_DIV: begin
                if (i_sts.cnt_zero) n_state = css_pkg::S_RES;
            end
            css_pkg::S_RES: begin
                if (i_sts.out_free) n_state = css_pkg::S_IDLE;
            end
            default: begin
                n_state = css_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != css_pkg::S_IDLE);
        case (r_state)
            css_pkg::S_MUL_LD:  o_cmd.load_mul  = 1'b1;
            css_pkg::S_MUL:     o_cmd.step_mul  = 1'b1;
            css_pkg::S_SQRT_LD: o_cmd.load_sqrt = 1'b1;
            css_pkg::S_SQRT:    o_cmd.step_sqrt = 1'b1;
            css_pkg::S_DIV_LD:  o_cmd.load_div  = 1'b1;
            css_pkg::S_DIV:     o_cmd.step_div  = 1'b1;
            css_pkg::S_RES:     o_cmd.load_out  = i_sts.out_free;
            default:            o_cmd           = '0;
        endcase
    end

endmodule

@@ rtl/css_dp.sv @@
// css_dp: product stage, saturating accumulators, shift-add multiplier,
// digit-by-digit square root, restoring divider and output register
// depends on css_pkg for widths, constants and the command and status structs
module css_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_accept,
    input  logic signed [css_pkg::ELEM_W-1:0] i_elem_a,
    input  logic signed [css_pkg::ELEM_W-1:0] i_elem_b,
    input  logic                              i_last,
    input  logic                              i_out_stall,
    input  css_pkg::t_cmd                     i_cmd,
    output css_pkg::t_sts                     o_sts,
    output logic                              o_out_valid,
    output logic signed [css_pkg::SIM_W-1:0]  o_similarity,
    output logic                              o_zero_norm
);

    // product stage
    logic                              r_p_valid;
    logic                              r_p_last;
    logic        [css_pkg::PROD_W-1:0] r_p_a;
    logic        [css_pkg::PROD_W-1:0] r_p_b;
    logic        [css_pkg::PROD_W-1:0] r_p_d;
    logic signed [css_pkg::PROD_W-1:0] prod_aa;
    logic signed [css_pkg::PROD_W-1:0] prod_bb;
    logic signed [css_pkg::PROD_W-1:0] prod_ab;

    // accumulators and snapshot of a finished vector
    logic [css_pkg::SQ_W-1:0]  r_acc_a;
    logic [css_pkg::SQ_W-1:0]  r_acc_b;
    logic [css_pkg::DOT_W-1:0] r_acc_dot;
    logic [css_pkg::SQ_W-1:0]  r_fin_a;
    logic [css_pkg::SQ_W-1:0]  r_fin_b;
    logic [css_pkg::DOT_W-1:0] r_fin_dot;
    logic [css_pkg::SQ_W:0]    sum_a;
    logic [css_pkg::SQ_W:0]    sum_b;
    logic [css_pkg::DOT_W:0]   sum_dot;
    logic [css_pkg::SQ_W-1:0]  n_acc_a;
    logic [css_pkg::SQ_W-1:0]  n_acc_b;
    logic [css_pkg::DOT_W-1:0] n_acc_dot;

    // finishing datapath
    logic [css_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_neg;
    logic [css_pkg::DOT_W-1:0]  r_mag;
    logic [css_pkg::WIDE_W-1:0] r_wide;
    logic [css_pkg::SQ_W-1:0]   r_mx;
    logic [css_pkg::SQ_W-1:0]   r_my;
    logic [css_pkg::WIDE_W-1:0] mul_sum;
    logic [css_pkg::REM_W-1:0]  r_rem;
    logic [css_pkg::ROOT_W-1:0] r_root;
    logic [css_pkg::REM_W+1:0]  sq_t;
    logic [css_pkg::REM_W+1:0]  sq_trial;
    logic [css_pkg::REM_W+1:0]  sq_diff;
    logic                       sq_ge;
    logic [css_pkg::DEN_W-1:0]  r_den;
    logic [css_pkg::DEN_W-1:0]  r_drem;
    logic [css_pkg::QUO_W-1:0]  r_nbits;
    logic [css_pkg::QUO_W-1:0]  r_quot;
    logic [css_pkg::DEN_W:0]    dv_t;
    logic [css_pkg::DEN_W:0]    dv_diff;
    logic                       dv_ge;

    // result
    logic                             zero_any;
    logic                             ovf;
    logic [css_pkg::QUO_W:0]          q_sum;
    logic [css_pkg::QUO_W-1:0]        q_rnd;
    logic signed [css_pkg::SIM_W-1:0] n_sim;
    logic                             r_out_valid;
    logic signed [css_pkg::SIM_W-1:0] r_sim;
    logic                             r_zn;

    // element products
    assign prod_aa = i_elem_a * i_elem_a;
    assign prod_bb = i_elem_b * i_elem_b;
    assign prod_ab = i_elem_a * i_elem_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_p_last <= i_last;
            r_p_a    <= prod_aa;
            r_p_b    <= prod_bb;
            r_p_d    <= prod_ab;
        end
    end

    // saturating sums
    always_comb begin
        sum_a   = {1'b0, r_acc_a} + {{(css_pkg::SQ_W + 1 - css_pkg::PROD_W){1'b0}}, r_p_a};
        sum_b   = {1'b0, r_acc_b} + {{(css_pkg::SQ_W + 1 - css_pkg::PROD_W){1'b0}}, r_p_b};
        sum_dot = {r_acc_dot[css_pkg::DOT_W-1], r_acc_dot}
                + {{(css_pkg::DOT_W + 1 - css_pkg::PROD_W){r_p_d[css_pkg::PROD_W-1]}}, r_p_d};
        n_acc_a = sum_a[css_pkg::SQ_W] ? '1 : sum_a[css_pkg::SQ_W-1:0];
        n_acc_b = sum_b[css_pkg::SQ_W] ? '1 : sum_b[css_pkg::SQ_W-1:0];
        if (sum_dot[css_pkg::DOT_W] != sum_dot[css_pkg::DOT_W-1]) begin
            n_acc_dot = sum_dot[css_pkg::DOT_W]
                      ? {1'b1, {(css_pkg::DOT_W-1){1'b0}}}
                      : {1'b0, {(css_pkg::DOT_W-1){1'b1}}};
        end else begin
            n_acc_dot = sum_dot[css_pkg::DOT_W-1:0];
        end
    end

    // accumulators, cleared once the last pair is in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_a   <= '0;
            r_acc_b   <= '0;
            r_acc_dot <= '0;
        end else if (r_p_valid) begin
            if (r_p_last) begin
                r_acc_a   <= '0;
                r_acc_b   <= '0;
                r_acc_dot <= '0;
            end else begin
                r_acc_a   <= n_acc_a;
                r_acc_b   <= n_acc_b;
                r_acc_dot <= n_acc_dot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid && r_p_last) begin
            r_fin_a   <= n_acc_a;
            r_fin_b   <= n_acc_b;
            r_fin_dot <= n_acc_dot;
        end
    end

    assign zero_any = (r_fin_a == '0) || (r_fin_b == '0);

    // shared step counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mul) begin
            r_cnt <= css_pkg::MUL_LAST;
        end else if (i_cmd.load_sqrt) begin
            r_cnt <= css_pkg::SQRT_LAST;
        end else if (i_cmd.load_div) begin
            r_cnt <= css_pkg::DIV_LAST;
        end else if (i_cmd.step_mul || i_cmd.step_sqrt || i_cmd.step_div) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // shift-add multiply, msb of the multiplier first
    assign mul_sum = {r_wide[css_pkg::WIDE_W-2:0], 1'b0}
                   + (r_my[css_pkg::SQ_W-1]
                      ? {{(css_pkg::WIDE_W - css_pkg::SQ_W){1'b0}}, r_mx}
                      : {css_pkg::WIDE_W{1'b0}});

    // square root, two radicand bits per step
    always_comb begin
        sq_t     = {r_rem, r_wide[css_pkg::WIDE_W-1 -: 2]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_diff  = sq_t - sq_trial;
        sq_ge    = (sq_t >= sq_trial);
    end

    // restoring divide, one quotient bit per step
    always_comb begin
        dv_t    = {r_drem, r_nbits[css_pkg::QUO_W-1]};
        dv_diff = dv_t - {1'b0, r_den};
        dv_ge   = (dv_t >= {1'b0, r_den});
    end

    // magnitude and sign of the dot product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mul) begin
            r_neg <= r_fin_dot[css_pkg::DOT_W-1];
            r_mag <= r_fin_dot[css_pkg::DOT_W-1] ? (~r_fin_dot + 1'b1) : r_fin_dot;
        end
    end

    // product register, reused as the radicand
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mul) begin
            r_wide <= '0;
            r_mx   <= r_fin_a;
            r_my   <= r_fin_b;
        end else if (i_cmd.step_mul) begin
            r_wide <= mul_sum;
            r_my   <= {r_my[css_pkg::SQ_W-2:0], 1'b0};
        end else if (i_cmd.step_sqrt) begin
            r_wide <= {r_wide[css_pkg::WIDE_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sqrt) begin
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.step_sqrt) begin
            r_rem  <= sq_ge ? sq_diff[css_pkg::REM_W-1:0] : sq_t[css_pkg::REM_W-1:0];
            r_root <= {r_root[css_pkg::ROOT_W-2:0], sq_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_den   <= {1'b0, r_root} + css_pkg::EPS_FIX;
            r_drem  <= {1'b0, r_mag[css_pkg::DOT_W-1:1]};
            r_nbits <= {r_mag[0], {(css_pkg::QUO_W-1){1'b0}}};
            r_quot  <= '0;
        end else if (i_cmd.step_div) begin
            r_drem  <= dv_ge ? dv_diff[css_pkg::DEN_W-1:0] : dv_t[css_pkg::DEN_W-1:0];
            r_nbits <= {r_nbits[css_pkg::QUO_W-2:0], 1'b0};
            r_quot  <= {r_quot[css_pkg::QUO_W-2:0], dv_ge};
        end
    end

    // rounding and saturation of the quotient
    always_comb begin
        ovf   = ({1'b0, r_mag} >= {r_den, 1'b0});
        q_sum = {1'b0, r_quot} + 1'b1;
        q_rnd = q_sum[css_pkg::QUO_W:1];
        if (zero_any) begin
            n_sim = '0;
        end else if (r_neg) begin
            n_sim = (ovf || (q_rnd > css_pkg::SIM_NEG_MAX))
                  ? {1'b1, {(css_pkg::SIM_W-1){1'b0}}}
                  : css_pkg::SIM_W'(0) - q_rnd[css_pkg::SIM_W-1:0];
        end else begin
            n_sim = (ovf || (q_rnd > css_pkg::SIM_POS_MAX))
                  ? {1'b0, {(css_pkg::SIM_W-1){1'b1}}}
                  : q_rnd[css_pkg::SIM_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_sim <= n_sim;
            r_zn  <= zero_any;
        end
    end

    // status and outputs
    assign o_sts.zero_norm = zero_any;
    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_similarity    = r_sim;
    assign o_zero_norm     = r_zn;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a stalled result");

    // accumulators are clear right after the last pair leaves the product stage
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && r_p_last) |=>
            (r_acc_a == '0 && r_acc_b == '0 && r_acc_dot == '0))
        else $error("accumulators not cleared after last pair");

    // no transaction follows a last pair directly
    a_hold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_accept && i_last) |=> !i_in_accept)
        else $error("input taken while finishing a vector");

    // zero flag of a new result matches the finished sums
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> (o_zero_norm == zero_any))
        else $error("zero norm flag does not match sums");

endmodule

@@ dv/cosine_similarity_stream_tb.sv @@
// cosine_similarity_stream_tb: self-checking testbench that streams element pairs and
// compares each vector's similarity result against an in-bench fixed-point predictor
// depends on css_pkg and cosine_similarity_stream
module cosine_similarity_stream_tb;

    // widths and constants taken from the package
    localparam int ELEM_W = css_pkg::ELEM_W;
    localparam int SIM_W  = css_pkg::SIM_W;
    localparam int SQ_W   = css_pkg::SQ_W;
    localparam int DOT_W  = css_pkg::DOT_W;
    localparam longint unsigned EPS_FIX     = css_pkg::EPS_FIX;
    localparam longint unsigned SIM_POS_MAX = css_pkg::SIM_POS_MAX;
    localparam longint unsigned SIM_NEG_MAX = css_pkg::SIM_NEG_MAX;

    // idling profile carried by each queued pair
    typedef enum logic [1:0] {
        PH_RX_BUSY,
        PH_TX_BUSY,
        PH_NO_IDLE
    } t_idle_phase;

    // content style of a random vector
    typedef enum logic [2:0] {
        VK_RANDOM,
        VK_SAME,
        VK_NEGATED,
        VK_A_ZERO,
        VK_B_ZERO,
        VK_SMALL,
        VK_EXTREME
    } t_vec_kind;

    typedef struct {
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic                     last;
        t_idle_phase              phase;
        logic                     hold;
    } t_pair;

    typedef struct {
        logic signed [SIM_W-1:0] sim;
        logic                    zero_norm;
    } t_cos_result;

    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
    localparam longint unsigned SQ_LIMIT = (64'd1 << SQ_W) - 64'd1;
    localparam longint DOT_HI = (longint'(1) <<< (DOT_W - 1)) - 1;
    localparam longint DOT_LO = -DOT_HI - 1;
    localparam int ROOT_BITS    = SQ_W + 1;
    localparam int PROD_SQ_BITS = 2 * SQ_W + 2;
    localparam int FRAC_SHIFT   = ELEM_W - 1;
    localparam int TX_IDLE_SLOW = 30;
    localparam int RX_IDLE_SLOW = 88;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic signed [ELEM_W-1:0] elem_a    = '0;
    logic signed [ELEM_W-1:0] elem_b    = '0;
    logic                     pair_last = 1'b0;
    logic                     out_stall = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic signed [SIM_W-1:0]  similarity;
    logic                     zero_norm;

    // stimulus and prediction state
    t_pair            pending_pairs[$];
    t_cos_result      sim_expected[$];
    longint unsigned  acc_sq_a  = 0;
    longint unsigned  acc_sq_b  = 0;
    longint           acc_dot   = 0;
    t_idle_phase      rx_phase  = PH_RX_BUSY;
    logic             hold_go   = 1'b0;
    int               hold_left = 0;
    int               err_cnt   = 0;
    int               cyc_cnt   = 0;

    cosine_similarity_stream i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_elem_a     (elem_a),
        .i_elem_b     (elem_b),
        .i_last       (pair_last),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_similarity (similarity),
        .o_zero_norm  (zero_norm)
    );

    // clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run length guard
    always @(posedge clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cyc_cnt);
            $display("cosine_similarity_stream verification failed");
            $finish;
        end
    end

    function automatic void push_pair(input logic signed [ELEM_W-1:0] a,
                                      input logic signed [ELEM_W-1:0] b,
                                      input logic last, input t_idle_phase phase,
                                      input logic hold);
        t_pair p;
        p.a     = a;
        p.b     = b;
        p.last  = last;
        p.phase = phase;
        p.hold  = hold;
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    // mix of full-range, extreme and small element values
    function automatic logic signed [ELEM_W-1:0] rand_elem();
        logic signed [ELEM_W-1:0] v;
        case ($urandom_range(3))
            0, 1: v = ELEM_W'($urandom);
            2: begin
                case ($urandom_range(4))
                    0: v = ELEM_MIN;
                    1: v = ELEM_MAX;
                    2: v = -16'sd1;
                    3: v = 16'sd1;
                    default: v = '0;
                endcase
            end
            default: v = ELEM_W'($urandom_range(127)) - 16'sd64;
        endcase
        return v;
    endfunction

    // queue one vector of random length and style, returns its pair count
    function automatic int add_random_vector(input t_idle_phase phase);
        int len;
        int i;
        t_vec_kind kind;
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(64, 9);
        end else begin
            len = $urandom_range(8, 1);
        end
        kind = t_vec_kind'($urandom_range(VK_EXTREME));
        for (i = 0; i < len; i++) begin
            a = rand_elem();
            b = rand_elem();
            case (kind)
                VK_SAME: b = a;
                VK_NEGATED: b = -a;
                VK_A_ZERO: a = '0;
                VK_B_ZERO: b = '0;
                VK_SMALL: begin
                    a = a >>> 10;
                    b = b >>> 10;
                end
                VK_EXTREME: begin
                    a = $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
                    b = $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
                end
                default: ;
            endcase
            push_pair(a, b, i == len - 1, phase, 1'b0);
        end
        return len;
    endfunction

    // fold one accepted pair into the sums, on the last pair predict the similarity
    function automatic void accumulate_pair(input logic signed [ELEM_W-1:0] a,
                                            input logic signed [ELEM_W-1:0] b,
                                            input logic end_of_vec);
        longint unsigned sq_a;
        longint unsigned sq_b;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned quo;
        longint prod;
        longint dsum;
        logic [PROD_SQ_BITS-1:0] prod_sq;
        logic [ROOT_BITS-1:0] root;
        logic [ROOT_BITS-1:0] trial;
        logic neg;
        int k;
        t_cos_result res;
        sq_a = longint'(a) * longint'(a);
        sq_b = longint'(b) * longint'(b);
        prod = longint'(a) * longint'(b);
        // saturating accumulation
        acc_sq_a = (acc_sq_a + sq_a > SQ_LIMIT) ? SQ_LIMIT : acc_sq_a + sq_a;
        acc_sq_b = (acc_sq_b + sq_b > SQ_LIMIT) ? SQ_LIMIT : acc_sq_b + sq_b;
        dsum = acc_dot + prod;
        acc_dot = (dsum > DOT_HI) ? DOT_HI : ((dsum < DOT_LO) ? DOT_LO : dsum);
        if (end_of_vec) begin
            if (acc_sq_a == 0 || acc_sq_b == 0) begin
                res.sim       = '0;
                res.zero_norm = 1'b1;
            end else begin
                // exact floor of the root of the product of the squared norms
                prod_sq = PROD_SQ_BITS'(acc_sq_a) * PROD_SQ_BITS'(acc_sq_b);
                root = '0;
                for (k = ROOT_BITS - 1; k >= 0; k--) begin
                    trial = root | (ROOT_BITS'(1) << k);
                    if (PROD_SQ_BITS'(trial) * PROD_SQ_BITS'(trial) <= prod_sq) begin
                        root = trial;
                    end
                end
                den = 64'(root) + 64'(EPS_FIX);
                neg = acc_dot < 0;
                if (neg) begin
                    mag = -acc_dot;
                end else begin
                    mag = acc_dot;
                end
                // round half away from zero, then clip to the q1.15 range
                num = mag << FRAC_SHIFT;
                quo = (2 * num + den) / (2 * den);
                if (neg) begin
                    if (quo > 64'(SIM_NEG_MAX)) begin
                        quo = 64'(SIM_NEG_MAX);
                    end
                    res.sim = SIM_W'(64'd0 - quo);
                end else begin
                    if (quo > 64'(SIM_POS_MAX)) begin
                        quo = 64'(SIM_POS_MAX);
                    end
                    res.sim = SIM_W'(quo);
                end
                res.zero_norm = 1'b0;
            end
            sim_expected.insert(sim_expected.size(), res);
            acc_sq_a = 0;
            acc_sq_b = 0;
            acc_dot  = 0;
        end
    endfunction

    // input driver: predicts on each accepted transaction, then offers the next pair
    always @(posedge clk) begin : drive_pairs
        int idle_pct;
        logic next_valid;
        logic next_hold;
        t_pair item;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                accumulate_pair(elem_a, elem_b, pair_last);
            end
            next_hold = 1'b0;
            if (!in_valid || !in_stall) begin
                next_valid = 1'b0;
                if (pending_pairs.size() != 0) begin
                    case (pending_pairs[0].phase)
                        PH_RX_BUSY: idle_pct = TX_IDLE_SLOW;
                        PH_TX_BUSY: idle_pct = RX_IDLE_SLOW;
                        default: idle_pct = 0;
                    endcase
                    if ($urandom_range(99) >= idle_pct) begin
                        item = pending_pairs.pop_front();
                        elem_a     <= item.a;
                        elem_b     <= item.b;
                        pair_last  <= item.last;
                        rx_phase   <= item.phase;
                        next_hold  = item.hold;
                        next_valid = 1'b1;
                    end
                end
                in_valid <= next_valid;
            end
            hold_go <= next_hold;
        end
    end

    // result monitor and receiver stall
    always @(posedge clk) begin : watch_results
        int stall_pct;
        t_cos_result want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (sim_expected.size() == 0) begin
                    $display("%0t: result with none expected: similarity %0d zero_norm %0b",
                             $time, similarity, zero_norm);
                    err_cnt++;
                end else begin
                    want = sim_expected.pop_front();
                    if (similarity !== want.sim) begin
                        $display("%0t: similarity mismatch: expected %0d, actual %0d",
                                 $time, want.sim, similarity);
                        err_cnt++;
                    end
                    if (zero_norm !== want.zero_norm) begin
                        $display("%0t: zero_norm mismatch: expected %0b, actual %0b",
                                 $time, want.zero_norm, zero_norm);
                        err_cnt++;
                    end
                end
            end
            // long hold-off first, else random stall by phase
            if (hold_go) begin
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else begin
                case (rx_phase)
                    PH_RX_BUSY: stall_pct = RX_IDLE_SLOW;
                    PH_TX_BUSY: stall_pct = TX_IDLE_SLOW;
                    default: stall_pct = 0;
                endcase
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : run_test
        int n_random;
        int k;
        // single-pair vectors at the range ends, zero norms and tiny norms
        push_pair(ELEM_MIN, ELEM_MIN, 1'b1, PH_RX_BUSY, 1'b0);
        push_pair(ELEM_MIN, ELEM_MAX, 1'b1, PH_RX_BUSY, 1'b0);
        push_pair(ELEM_MAX, ELEM_MIN, 1'b1, PH_RX_BUSY, 1'b0);
        push_pair(ELEM_MAX, ELEM_MAX, 1'b1, PH_RX_BUSY, 1'b0);
        push_pair(16'sd0, 16'sd0, 1'b1, PH_RX_BUSY, 1'b0);
        push_pair(16'sd0, ELEM_MIN, 1'b1, PH_RX_BUSY, 1'b0);
        push_pair(ELEM_MIN, 16'sd0, 1'b1, PH_RX_BUSY, 1'b0);
        push_pair(16'sd1, 16'sd1, 1'b1, PH_RX_BUSY, 1'b0);
        push_pair(16'sd1, -16'sd1, 1'b1, PH_RX_BUSY, 1'b0);
        push_pair(-16'sd1, -16'sd1, 1'b1, PH_RX_BUSY, 1'b0);
        // orthogonal vectors
        push_pair(16'sd16384, 16'sd0, 1'b0, PH_RX_BUSY, 1'b0);
        push_pair(16'sd0, 16'sd16384, 1'b1, PH_RX_BUSY, 1'b0);
        // mixed multi-pair vector
        push_pair(ELEM_MAX, ELEM_MAX, 1'b0, PH_RX_BUSY, 1'b0);
        push_pair(ELEM_MIN, ELEM_MIN, 1'b0, PH_RX_BUSY, 1'b0);
        push_pair(16'sd12345, -16'sd23456, 1'b1, PH_RX_BUSY, 1'b0);
        // first vector all zero over two pairs
        push_pair(16'sd0, 16'sd100, 1'b0, PH_RX_BUSY, 1'b0);
        push_pair(16'sd0, -16'sd100, 1'b1, PH_RX_BUSY, 1'b0);
        // tiny norm against a large one
        push_pair(16'sd1, ELEM_MIN, 1'b0, PH_RX_BUSY, 1'b0);
        push_pair(-16'sd1, ELEM_MAX, 1'b1, PH_RX_BUSY, 1'b0);

        // random vectors, receiver mostly stalled
        n_random = 0;
        while (n_random < 110) begin
            n_random += add_random_vector(PH_RX_BUSY);
        end
        // random vectors, sender mostly idle
        n_random = 0;
        while (n_random < 110) begin
            n_random += add_random_vector(PH_TX_BUSY);
        end
        // long receiver hold-off while short vectors keep coming
        push_pair(16'sd100, 16'sd200, 1'b1, PH_NO_IDLE, 1'b1);
        for (k = 0; k < 8; k++) begin
            void'(add_random_vector(PH_NO_IDLE));
        end
        // random vectors with no idling
        n_random = 0;
        while (n_random < 100) begin
            n_random += add_random_vector(PH_NO_IDLE);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || in_valid) begin
            @(negedge clk);
        end
        while (sim_expected.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (err_cnt == 0) begin
            $display("cosine_similarity_stream verification clean");
        end else begin
            $display("cosine_similarity_stream verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/css_pkg.sv
rtl/css_ctrl.sv
rtl/css_dp.sv
rtl/cosine_similarity_stream.sv
dv/cosine_similarity_stream_tb.sv
